// ===== rtl/fpcc_pkg.sv =====
// Shared types and constants of the flash pack command controller.
// No dependencies; all other files but fpcc_ram refer to this package by scoped names.
package fpcc_pkg;

    localparam int unsigned PACK_BYTES = 1048576;
    localparam int unsigned PAGE_BYTES = 65536;
    localparam int unsigned MEM_AW     = $clog2(PACK_BYTES);
    localparam int unsigned CMP_W      = (MEM_AW >= 20) ? MEM_AW + 1 : 21;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);

    localparam logic [MEM_AW-1:0] PAGE_LAST = MEM_AW'(PAGE_BYTES - 1);
    localparam logic [MEM_AW-1:0] PACK_LAST = MEM_AW'(PACK_BYTES - 1);

    localparam logic [3:0] SIZE_RESET = 4'd10;
    localparam logic [3:0] SIZE_MAX   = 4'd12;

    // flash command bytes
    localparam logic [7:0] FC_RESET0   = 8'h00;
    localparam logic [7:0] FC_RESET1   = 8'hFF;
    localparam logic [7:0] FC_PROG0    = 8'h10;
    localparam logic [7:0] FC_PROG1    = 8'h40;
    localparam logic [7:0] FC_STATUS   = 8'h70;
    localparam logic [7:0] FC_EXT      = 8'h71;
    localparam logic [7:0] FC_VENDOR   = 8'h75;
    localparam logic [15:0] FC_ERASE_PAGE = 16'h20D0;
    localparam logic [15:0] FC_ERASE_ALL  = 16'hA7D0;

    // read-back bytes
    localparam logic [7:0] RB_EXT2     = 8'hC0;
    localparam logic [7:0] RB_EXT4     = 8'h82;
    localparam logic [7:0] RB_STATUS   = 8'h80;
    localparam logic [7:0] RB_VEND0    = 8'h4D;
    localparam logic [7:0] RB_VEND2    = 8'h50;
    localparam logic [7:0] RB_SIZE_HI  = 8'h10;
    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    localparam logic [14:0] VEND_LO = 15'h7F00;
    localparam logic [14:0] VEND_HI = 15'h7F13;
    localparam logic [7:0]  VEND_OFS_ID   = 8'h00;
    localparam logic [7:0]  VEND_OFS_TYPE = 8'h02;
    localparam logic [7:0]  VEND_OFS_SIZE = 8'h06;
    localparam logic [11:0] EXT_OFS2 = 12'h002;
    localparam logic [11:0] EXT_OFS4 = 12'h004;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_LOAD  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        OP_CONST,
        OP_READ,
        OP_PROG,
        OP_LOAD,
        OP_ERASE_PAGE,
        OP_ERASE_ALL
    } t_op_kind;

    typedef struct packed {
        t_op_kind          kind;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        data;
    } t_op;

    typedef struct packed {
        logic pop;
        logic erasing;
    } t_back_stat;

endpackage

// ===== rtl/flash_pack_command_controller.sv =====
// Top level of the flash pack command controller.
// Uses fpcc_pkg; instantiates fpcc_front, fpcc_queue and fpcc_back.
//
// Requests: drive i_command, i_flash_address, i_bus_low and i_write_data with
// start high; the request is taken at a clock edge where busy is low.
// Every request gives exactly one result: o_read_data is valid in the one
// cycle that o_strobe is high, in request order. The receiver cannot stall.
// Configuration: i_cfg_data, capped at SIZE_MAX, is written to the size code
// when i_cfg_valid is high; o_cfg_ready is always high.
// Flow: each request is queued; the back end pops it and registers its result.
// Stored-byte reads and byte programs first pass a read or program state.
// Throughput: one request per cycle for requests needing no store read, outside
// erase sweeps; reads and programs stop in that state for the single RAM port.
// Erase: a page erase fills addresses 0 to PAGE_LAST with ERASED_BYTE, a chip
// erase the whole store; requests queue (four deep) and busy rises when full.
// Reset clears flags, history, queue and size code (to 10); the store keeps
// its content and is undefined until loaded.
module flash_pack_command_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [19:0] i_flash_address,
    input  logic [14:0] i_bus_low,
    input  logic [7:0]  i_write_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    output logic        o_strobe,
    output logic [7:0]  o_read_data
);

    logic accept;
    logic q_empty;
    logic q_full;
    fpcc_pkg::t_op        op;
    fpcc_pkg::t_op        head;
    fpcc_pkg::t_back_stat bstat;

    assign busy        = q_full;
    assign accept      = start && !q_full;
    assign o_cfg_ready = 1'b1;

    fpcc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_command      (i_command),
        .i_flash_address(i_flash_address),
        .i_bus_low      (i_bus_low),
        .i_write_data   (i_write_data),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_op           (op)
    );

    fpcc_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (accept),
        .i_op   (op),
        .i_pop  (bstat.pop),
        .o_head (head),
        .o_empty(q_empty),
        .o_full (q_full)
    );

    fpcc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_empty    (q_empty),
        .o_stat     (bstat),
        .o_strobe   (o_strobe),
        .o_read_data(o_read_data)
    );

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bstat.pop |-> !q_empty)
        else $error("pop from empty queue");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && q_empty) |=> !q_empty)
        else $error("accepted request lost");

    a_no_pop_in_erase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bstat.erasing |-> !bstat.pop)
        else $error("pop during erase sweep");

    a_quiet_in_erase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (bstat.erasing && $past(bstat.erasing)) |-> !o_strobe)
        else $error("result during erase sweep");

endmodule

// ===== rtl/fpcc_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module fpcc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fpcc_front.sv =====
// Front end: takes requests, keeps status flags and command history,
// and turns each request into one operation for the back end. Uses fpcc_pkg.
module fpcc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [1:0]         i_command,
    input  logic [19:0]        i_flash_address,
    input  logic [14:0]        i_bus_low,
    input  logic [7:0]         i_write_data,
    input  logic               i_cfg_valid,
    input  logic [3:0]         i_cfg_data,
    output fpcc_pkg::t_op      o_op
);

    logic        r_status_once, n_status_once;
    logic        r_ext_status, n_ext_status;
    logic        r_vendor, n_vendor;
    logic        r_armed, n_armed;
    logic [15:0] r_history, n_history;
    logic [3:0]  r_size, n_size;

    logic in_pack;
    logic in_vendor;
    fpcc_pkg::t_op op;

    assign in_pack = fpcc_pkg::CMP_W'(i_flash_address) < fpcc_pkg::CMP_W'(fpcc_pkg::PACK_BYTES);
    assign in_vendor = (i_bus_low >= fpcc_pkg::VEND_LO) && (i_bus_low <= fpcc_pkg::VEND_HI);

    always_comb begin
        n_status_once = r_status_once;
        n_ext_status  = r_ext_status;
        n_vendor      = r_vendor;
        n_armed       = r_armed;
        n_history     = r_history;
        n_size        = r_size;
        op.kind       = fpcc_pkg::OP_CONST;
        op.addr       = fpcc_pkg::MEM_AW'(i_flash_address);
        op.data       = '0;

        if (i_cfg_valid) begin
            n_size = (i_cfg_data > fpcc_pkg::SIZE_MAX) ? fpcc_pkg::SIZE_MAX : i_cfg_data;
        end

        if (i_accept) begin
            case (fpcc_pkg::t_cmd'(i_command))
                fpcc_pkg::CMD_READ: begin
                    if (r_ext_status && (i_flash_address[19:12] == 8'd0) &&
                        (i_flash_address[11:0] == fpcc_pkg::EXT_OFS2)) begin
                        op.data = fpcc_pkg::RB_EXT2;
                    end else if (r_ext_status && (i_flash_address[19:12] == 8'd0) &&
                                 (i_flash_address[11:0] == fpcc_pkg::EXT_OFS4)) begin
                        op.data = fpcc_pkg::RB_EXT4;
                    end else if (r_status_once) begin
                        op.data       = fpcc_pkg::RB_STATUS;
                        n_status_once = 1'b0;
                    end else if (r_vendor && in_vendor) begin
                        case (i_bus_low[7:0])
                            fpcc_pkg::VEND_OFS_ID:   op.data = fpcc_pkg::RB_VEND0;
                            fpcc_pkg::VEND_OFS_TYPE: op.data = fpcc_pkg::RB_VEND2;
                            fpcc_pkg::VEND_OFS_SIZE: op.data = fpcc_pkg::RB_SIZE_HI | {4'd0, r_size};
                            default:                 op.data = '0;
                        endcase
                    end else if (in_pack) begin
                        op.kind = fpcc_pkg::OP_READ;
                    end
                end
                fpcc_pkg::CMD_WRITE: begin
                    if (r_armed) begin
                        n_armed = 1'b0;
                        if (in_pack) begin
                            op.kind = fpcc_pkg::OP_PROG;
                            op.data = i_write_data;
                        end
                    end else if (i_flash_address == 20'd0) begin
                        n_history = {r_history[7:0], i_write_data};
                        case (i_write_data)
                            fpcc_pkg::FC_RESET0, fpcc_pkg::FC_RESET1: begin
                                n_status_once = 1'b0;
                                n_ext_status  = 1'b0;
                                n_vendor      = 1'b0;
                            end
                            fpcc_pkg::FC_PROG0, fpcc_pkg::FC_PROG1: n_armed = 1'b1;
                            fpcc_pkg::FC_STATUS: n_status_once = 1'b1;
                            fpcc_pkg::FC_EXT:    n_ext_status  = 1'b1;
                            fpcc_pkg::FC_VENDOR: n_vendor      = 1'b1;
                            default: ;
                        endcase
                        if (n_history == fpcc_pkg::FC_ERASE_PAGE) begin
                            op.kind = fpcc_pkg::OP_ERASE_PAGE;
                        end else if (n_history == fpcc_pkg::FC_ERASE_ALL) begin
                            op.kind = fpcc_pkg::OP_ERASE_ALL;
                        end
                    end
                end
                fpcc_pkg::CMD_LOAD: begin
                    if (in_pack) begin
                        op.kind = fpcc_pkg::OP_LOAD;
                        op.data = i_write_data;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status_once <= 1'b0;
            r_ext_status  <= 1'b0;
            r_vendor      <= 1'b0;
            r_armed       <= 1'b0;
            r_history     <= '0;
            r_size        <= fpcc_pkg::SIZE_RESET;
        end else begin
            r_status_once <= n_status_once;
            r_ext_status  <= n_ext_status;
            r_vendor      <= n_vendor;
            r_armed       <= n_armed;
            r_history     <= n_history;
            r_size        <= n_size;
        end
    end

    assign o_op = op;

endmodule

// ===== rtl/fpcc_queue.sv =====
// Short operation queue between the front and back ends.
// Uses fpcc_pkg for the operation type and depth.
module fpcc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fpcc_pkg::t_op i_op,
    input  logic          i_pop,
    output fpcc_pkg::t_op o_head,
    output logic          o_empty,
    output logic          o_full
);

    fpcc_pkg::t_op r_slot [fpcc_pkg::QUEUE_DEPTH];
    logic [fpcc_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [fpcc_pkg::QPTR_W:0]   r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (fpcc_pkg::QPTR_W + 1)'(fpcc_pkg::QUEUE_DEPTH));
    assign o_head  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/fpcc_back.sv =====
// Back end: carries out queued operations on the flash store and emits results.
// Uses fpcc_pkg and instantiates fpcc_ram.
module fpcc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fpcc_pkg::t_op        i_head,
    input  logic                 i_empty,
    output fpcc_pkg::t_back_stat o_stat,
    output logic                 o_strobe,
    output logic [7:0]           o_read_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_PROG,
        S_ERASE
    } t_state;

    t_state r_state, n_state;
    logic   r_strobe, n_strobe;
    logic [7:0] r_rdata, n_rdata;
    logic [fpcc_pkg::MEM_AW-1:0] r_addr, n_addr;
    logic [fpcc_pkg::MEM_AW-1:0] r_last, n_last;
    logic [7:0] r_data, n_data;

    logic pop;
    logic ram_we;
    logic [fpcc_pkg::MEM_AW-1:0] ram_addr;
    logic [7:0] ram_wdata;
    logic [7:0] ram_rdata;

    fpcc_ram #(
        .WIDTH(8),
        .DEPTH(fpcc_pkg::PACK_BYTES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_strobe  = 1'b0;
        n_rdata   = r_rdata;
        n_addr    = r_addr;
        n_last    = r_last;
        n_data    = r_data;
        pop       = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = i_head.addr;
        ram_wdata = i_head.data;

        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    pop    = 1'b1;
                    n_addr = i_head.addr;
                    n_data = i_head.data;
                    case (i_head.kind)
                        fpcc_pkg::OP_READ: n_state = S_READ;
                        fpcc_pkg::OP_PROG: n_state = S_PROG;
                        fpcc_pkg::OP_LOAD: begin
                            ram_we   = 1'b1;
                            n_strobe = 1'b1;
                            n_rdata  = '0;
                        end
                        fpcc_pkg::OP_ERASE_PAGE: begin
                            n_strobe = 1'b1;
                            n_rdata  = '0;
                            n_addr   = '0;
                            n_last   = fpcc_pkg::PAGE_LAST;
                            n_state  = S_ERASE;
                        end
                        fpcc_pkg::OP_ERASE_ALL: begin
                            n_strobe = 1'b1;
                            n_rdata  = '0;
                            n_addr   = '0;
                            n_last   = fpcc_pkg::PACK_LAST;
                            n_state  = S_ERASE;
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_rdata  = i_head.data;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_strobe = 1'b1;
                n_rdata  = ram_rdata;
                n_state  = S_IDLE;
            end
            S_PROG: begin
                ram_we    = 1'b1;
                ram_addr  = r_addr;
                ram_wdata = r_data & ram_rdata;
                n_strobe  = 1'b1;
                n_rdata   = '0;
                n_state   = S_IDLE;
            end
            S_ERASE: begin
                ram_we    = 1'b1;
                ram_addr  = r_addr;
                ram_wdata = fpcc_pkg::ERASED_BYTE;
                if (r_addr == r_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
        r_rdata <= n_rdata;
        r_addr  <= n_addr;
        r_last  <= n_last;
        r_data  <= n_data;
    end

    assign o_stat.pop     = pop;
    assign o_stat.erasing = (r_state == S_ERASE);
    assign o_strobe       = r_strobe;
    assign o_read_data    = r_rdata;

endmodule
